// ----- src/kei_pkg.sv -----
// ---------------------------------------------------------------------------
// kei_pkg
// Shared constants and codes for the keyframe easing interpolator.
// ---------------------------------------------------------------------------
package kei_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH         = 32;

    typedef enum logic [1:0] {
        EASE_LINEAR = 2'd0,
        EASE_IN     = 2'd1,
        EASE_OUT    = 2'd2,
        EASE_HOLD   = 2'd3
    } easing_t;

endpackage

// ----- src/keyframe_easing_interpolator.sv -----
// ---------------------------------------------------------------------------
// keyframe_easing_interpolator
// Scans keyframe segments and returns the eased value at the query time.
// ---------------------------------------------------------------------------
// One item is taken at a time. Items that pass a segment, stop before one or
// carry no segment are settled in the idle state, and an item marked last
// passes through the emit state to hand its result on. The segment that holds
// the time, unless its easing is hold, runs through a bit-serial datapath:
// shift-add squaring for the quadratic easings, a shift-add multiply, a combine
// step, restoring division (one quotient bit per cycle) and a rounding step.
// A result waits in the output register until it is taken.
module keyframe_easing_interpolator #(
    parameter int VALUE_WIDTH = kei_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_first_segment,
    input  logic                s_last_segment,
    input  logic                s_has_segment,
    input  logic signed [31:0]  s_now_time,
    input  logic signed [31:0]  s_repeat_time,
    input  logic signed [31:0]  s_initial_value,
    input  logic signed [31:0]  s_seg_start,
    input  logic signed [31:0]  s_seg_end,
    input  logic signed [31:0]  s_seg_value,
    input  logic        [1:0]   s_easing,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_value,
    output logic                m_saturated
);
    import kei_pkg::*;

    localparam int PW  = 97;  // product width, 33 x 64
    localparam int DW  = 98;  // dividend magnitude width
    localparam int QW  = 34;  // kept quotient bits
    localparam logic [6:0] SQ_LAST  = 7'd31;
    localparam logic [6:0] MUL_LAST = 7'd32;
    localparam logic [6:0] DIV_LAST = 7'(DW - 1);
    localparam logic signed [QW-1:0] LIM_HI = (34'sd1 <<< (VALUE_WIDTH - 1)) - 34'sd1;
    localparam logic signed [QW-1:0] LIM_LO = -(34'sd1 <<< (VALUE_WIDTH - 1));

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQUARE, ST_MUL, ST_COMB, ST_DIV, ST_ROUND, ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic signed [32:0]     time_reg;
    logic signed [31:0]     start_reg;
    logic                   done_reg;
    logic signed [QW-1:0]   held_reg;
    logic                   emit_reg;
    logic [6:0]             cnt_reg;

    logic [31:0]            sqx_reg, sqxb_reg, sqd_reg, sqdb_reg;
    logic [63:0]            accx_reg, accd_reg;
    logic [63:0]            den_reg, mult_reg;
    logic [32:0]            ma_reg, mb_reg;
    logic                   base_neg_reg, prod_neg_reg;
    logic [PW-1:0]          acc1_reg, acc2_reg;
    logic [DW-1:0]          dvd_reg;
    logic                   neg_reg;
    logic [63:0]            rem_reg;
    logic [QW-1:0]          q_reg;

    // item decode
    logic signed [32:0]     t_now, s33, e33, v33, st33, diff, base33;
    logic signed [31:0]     start_now, base_now;
    logic                   done_now;
    logic [32:0]            el_full, d_full, rm_full, diff_mag, base_mag;
    logic                   holds_time;

    always_comb begin
        t_now     = s_first_segment ? ({s_now_time[31], s_now_time}
                                       - {s_repeat_time[31], s_repeat_time}) : time_reg;
        start_now = s_first_segment ? s_initial_value : start_reg;
        done_now  = s_first_segment ? 1'b0 : done_reg;
        s33       = {s_seg_start[31], s_seg_start};
        e33       = {s_seg_end[31], s_seg_end};
        v33       = {s_seg_value[31], s_seg_value};
        st33      = {start_now[31], start_now};
        el_full   = 33'(t_now - s33);
        d_full    = 33'(e33 - s33);
        rm_full   = 33'(e33 - t_now);
        diff      = v33 - st33;
        diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
        base_now  = (easing_t'(s_easing) == EASE_OUT) ? s_seg_value : start_now;
        base33    = {base_now[31], base_now};
        base_mag  = base33[32] ? 33'(-base33) : 33'(base33);
        holds_time = !(t_now < s33) && !(t_now >= e33);
    end

    // bit-serial arithmetic steps
    logic [32:0]  sq_top_x, sq_top_d;
    logic [64:0]  mul_top1, mul_top2;
    logic signed [DW:0] sum1, sum2, tsum;
    logic [64:0]  div_shift;
    logic         div_ge;
    logic         round_up;
    logic [QW-1:0] q_round;
    logic signed [QW-1:0] res_clamped;
    logic          res_sat;

    always_comb begin
        sq_top_x = {1'b0, accx_reg[63:32]} + (sqxb_reg[0] ? {1'b0, sqx_reg} : 33'd0);
        sq_top_d = {1'b0, accd_reg[63:32]} + (sqdb_reg[0] ? {1'b0, sqd_reg} : 33'd0);
        mul_top1 = {1'b0, acc1_reg[PW-1:33]} + (ma_reg[0] ? {1'b0, den_reg} : 65'd0);
        mul_top2 = {1'b0, acc2_reg[PW-1:33]} + (mb_reg[0] ? {1'b0, mult_reg} : 65'd0);
        sum1     = base_neg_reg ? -$signed({2'b00, acc1_reg}) : $signed({2'b00, acc1_reg});
        sum2     = prod_neg_reg ? -$signed({2'b00, acc2_reg}) : $signed({2'b00, acc2_reg});
        tsum     = sum1 + sum2;
        div_shift = {rem_reg, dvd_reg[DW-1]};
        div_ge   = div_shift >= {1'b0, den_reg};
        round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
        q_round  = q_reg + QW'(round_up);
        res_sat  = 1'b0;
        res_clamped = held_reg;
        if (held_reg > LIM_HI) begin
            res_clamped = LIM_HI;
            res_sat     = 1'b1;
        end else if (held_reg < LIM_LO) begin
            res_clamped = LIM_LO;
            res_sat     = 1'b1;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            time_reg  <= '0;
            start_reg <= '0;
            done_reg  <= 1'b0;
            held_reg  <= '0;
            emit_reg  <= 1'b0;
            cnt_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        time_reg <= t_now;
                        start_reg <= start_now;
                        done_reg <= done_now;
                        emit_reg <= s_last_segment;
                        if (s_first_segment) begin
                            held_reg <= QW'(s_initial_value);
                        end
                        state_reg <= s_last_segment ? ST_EMIT : ST_IDLE;
                        if (s_has_segment && !done_now) begin
                            if (t_now < s33) begin
                                held_reg <= QW'(start_now);
                                done_reg <= 1'b1;
                            end else if (t_now >= e33) begin
                                start_reg <= s_seg_value;
                                held_reg <= QW'(s_seg_value);
                            end else begin
                                done_reg <= 1'b1;
                                if (easing_t'(s_easing) == EASE_HOLD) begin
                                    held_reg <= QW'(start_now);
                                end
                            end
                        end
                        if (s_has_segment && !done_now && holds_time
                            && easing_t'(s_easing) != EASE_HOLD) begin
                            sqx_reg  <= (easing_t'(s_easing) == EASE_OUT) ? rm_full[31:0]
                                                                           : el_full[31:0];
                            sqxb_reg <= (easing_t'(s_easing) == EASE_OUT) ? rm_full[31:0]
                                                                           : el_full[31:0];
                            sqd_reg  <= d_full[31:0];
                            sqdb_reg <= d_full[31:0];
                            accx_reg <= '0;
                            accd_reg <= '0;
                            ma_reg   <= base_mag;
                            mb_reg   <= diff_mag;
                            acc1_reg <= '0;
                            acc2_reg <= '0;
                            base_neg_reg <= base_now[31];
                            prod_neg_reg <= diff[32] ^ (easing_t'(s_easing) == EASE_OUT);
                            den_reg  <= {32'd0, d_full[31:0]};
                            mult_reg <= {32'd0, el_full[31:0]};
                            cnt_reg  <= '0;
                            state_reg <= (easing_t'(s_easing) == EASE_LINEAR) ? ST_MUL
                                                                               : ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE: begin
                    accx_reg <= {sq_top_x, accx_reg[31:1]};
                    accd_reg <= {sq_top_d, accd_reg[31:1]};
                    sqxb_reg <= sqxb_reg >> 1;
                    sqdb_reg <= sqdb_reg >> 1;
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (cnt_reg == SQ_LAST) begin
                        den_reg   <= {sq_top_d, accd_reg[31:1]};
                        mult_reg  <= {sq_top_x, accx_reg[31:1]};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    acc1_reg <= {mul_top1, acc1_reg[32:1]};
                    acc2_reg <= {mul_top2, acc2_reg[32:1]};
                    ma_reg   <= ma_reg >> 1;
                    mb_reg   <= mb_reg >> 1;
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= ST_COMB;
                    end
                end
                ST_COMB: begin
                    neg_reg   <= tsum[DW];
                    dvd_reg   <= tsum[DW] ? DW'(-tsum) : DW'(tsum);
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    dvd_reg <= dvd_reg << 1;
                    if (div_ge) begin
                        rem_reg <= 64'(div_shift - {1'b0, den_reg});
                    end else begin
                        rem_reg <= div_shift[63:0];
                    end
                    q_reg   <= {q_reg[QW-2:0], div_ge};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    held_reg  <= neg_reg ? -$signed(q_round) : $signed(q_round);
                    state_reg <= emit_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (!m_valid || m_ready) begin
                        m_valid     <= 1'b1;
                        m_value     <= res_clamped[31:0];
                        m_saturated <= res_sat;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/kei_checker.sv -----
// ---------------------------------------------------------------------------
// kei_checker
// Port-level checks for the keyframe easing interpolator.
// ---------------------------------------------------------------------------
module kei_checker #(
    parameter int VALUE_WIDTH = kei_pkg::DEFAULT_VALUE_WIDTH
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_value,
    input logic               m_saturated
);
    import kei_pkg::*;

    localparam logic signed [31:0] MAX_V = 32'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [31:0] MIN_V = 32'(-(64'sd1 <<< (VALUE_WIDTH - 1)));

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_saturated))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a clamped result sits on a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_value == MAX_V) || (m_value == MIN_V))
        else $error("saturated result off the limit");

    // a result is loaded only while the input side is held off
    a_emit_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result loaded while input open");

    // results stay within the configured range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value <= MAX_V) && (m_value >= MIN_V))
        else $error("result outside range");

endmodule

bind keyframe_easing_interpolator kei_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_kei_checker (.*);
